// ----- design/tasr_pkg.sv -----
// ----------------------------------------------------------------------------
// tasr_pkg: shared types and constants for the touch converter reader
// Payload structs, pin-level tick record, controller/datapath command bus.
// ----------------------------------------------------------------------------
package tasr_pkg;

  localparam int CFG_W  = 12;   // width of every configuration register
  localparam int POS_W  = 12;   // width of a position result
  localparam int IDX_W  = 3;    // configuration register index width
  localparam int BIT_W  = 4;    // serial bit counter width
  localparam int PROD_W = 2 * CFG_W;

  localparam int ADC_BITS_DEF = 12;
  localparam int TRAIL_DEF    = 3;
  localparam int CMD_BITS     = 8;

  localparam logic [CMD_BITS-1:0] CMD_X = 8'hD0;
  localparam logic [CMD_BITS-1:0] CMD_Y = 8'h90;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_X_LO   = 3'd0;
  localparam logic [IDX_W-1:0] REG_X_HI   = 3'd1;
  localparam logic [IDX_W-1:0] REG_Y_LO   = 3'd2;
  localparam logic [IDX_W-1:0] REG_Y_HI   = 3'd3;
  localparam logic [IDX_W-1:0] REG_X_SPAN = 3'd4;
  localparam logic [IDX_W-1:0] REG_Y_SPAN = 3'd5;

  localparam logic [CFG_W-1:0] RST_X_LO   = 12'd230;
  localparam logic [CFG_W-1:0] RST_X_HI   = 12'd3830;
  localparam logic [CFG_W-1:0] RST_Y_LO   = 12'd160;
  localparam logic [CFG_W-1:0] RST_Y_HI   = 12'd3860;
  localparam logic [CFG_W-1:0] RST_X_SPAN = 12'd240;
  localparam logic [CFG_W-1:0] RST_Y_SPAN = 12'd320;

  typedef struct packed {
    logic start_req;
    logic calibrate;
    logic miso_bit;
  } in_item_t;

  typedef struct packed {
    logic             chip_select_n;
    logic             serial_clock;
    logic             mosi_bit;
    logic             done_res;
    logic [POS_W-1:0] x_position;
    logic [POS_W-1:0] y_position;
    logic             busy_res;
  } out_item_t;

  // pin levels and flags for one tick, before the positions are attached
  typedef struct packed {
    logic chip_select_n;
    logic serial_clock;
    logic mosi_bit;
    logic done_res;
    logic busy_res;
  } line_t;

  typedef struct packed {
    logic  out_load;
    line_t line;
    logic  shift_clr;
    logic  shift_en;
    logic  calc_start;
    logic  mul_en;
    logic  div_start;
    logic  fin_store;
    logic  axis;
    logic  cal;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

// ----- design/tasr_div.sv -----
// ----------------------------------------------------------------------------
// tasr_div: restoring divider, one quotient bit per cycle
// Divides a PROD_W-bit numerator by a CFG_W-bit divisor; the caller
// guarantees the quotient fits in POS_W bits.
// ----------------------------------------------------------------------------
module tasr_div
  import tasr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] num_i,
  input  logic [CFG_W-1:0]  den_i,
  output logic [POS_W-1:0]  quo_o,
  output logic              done_o
);

  localparam int CNT_W = $clog2(POS_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(POS_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CFG_W-1:0] rem_q, rem_d;
  logic [POS_W-1:0] quo_q, quo_d;
  logic [CFG_W:0]   wide;
  logic [CFG_W:0]   sub;
  logic             ge;

  assign wide = {rem_q, quo_q[POS_W-1]};
  assign ge   = (wide >= {1'b0, den_i});
  assign sub  = wide - {1'b0, den_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = num_i[PROD_W-1:POS_W];
      quo_d  = num_i[POS_W-1:0];
    end else if (busy_q) begin
      rem_d = ge ? sub[CFG_W-1:0] : wide[CFG_W-1:0];
      quo_d = {quo_q[POS_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// ----- design/tasr_dp.sv -----
// ----------------------------------------------------------------------------
// tasr_dp: datapath of the touch converter reader
// Configuration registers, receive shifter, window check, scaling multiply,
// divider, axis results and the output register.
// ----------------------------------------------------------------------------
module tasr_dp
  import tasr_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             miso_i,
  input  dp_cmd_t          cmd_i,
  output dp_sts_t          sts_o,
  output out_item_t        out_o
);

  localparam int CMP_W = (ADC_BITS > CFG_W) ? ADC_BITS : CFG_W;

  logic [CFG_W-1:0]    x_lo_q, x_hi_q, y_lo_q, y_hi_q, x_span_q, y_span_q;
  logic [ADC_BITS-1:0] shift_q;
  logic [CFG_W-1:0]    diff_q, den_q, span_q;
  logic                win_q;
  logic [PROD_W-1:0]   prod_q;
  logic [POS_W-1:0]    x_res_q, y_res_q;
  out_item_t           out_q;

  logic [CMP_W-1:0]    raw_ext, lo_ext, hi_ext;
  logic [CFG_W-1:0]    lo, hi;
  logic                in_win;
  logic [CMP_W-1:0]    diff_w;
  logic [POS_W-1:0]    raw12, quo, val;
  logic                div_done;

  assign lo      = cmd_i.axis ? y_lo_q : x_lo_q;
  assign hi      = cmd_i.axis ? y_hi_q : x_hi_q;
  assign raw_ext = CMP_W'(shift_q);
  assign lo_ext  = CMP_W'(lo);
  assign hi_ext  = CMP_W'(hi);
  assign in_win  = (raw_ext >= lo_ext) && (raw_ext <= hi_ext) && (hi > lo);
  // Y axis reads inverted
  assign diff_w  = cmd_i.axis ? (hi_ext - raw_ext) : (raw_ext - lo_ext);
  assign raw12   = POS_W'(shift_q);
  assign val     = cmd_i.cal ? (win_q ? quo : '0) : raw12;

  tasr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_q),
    .den_i   (den_q),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  assign sts_o.div_done = div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_lo_q   <= RST_X_LO;
      x_hi_q   <= RST_X_HI;
      y_lo_q   <= RST_Y_LO;
      y_hi_q   <= RST_Y_HI;
      x_span_q <= RST_X_SPAN;
      y_span_q <= RST_Y_SPAN;
      shift_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_X_LO:   x_lo_q   <= cfg_data_i;
          REG_X_HI:   x_hi_q   <= cfg_data_i;
          REG_Y_LO:   y_lo_q   <= cfg_data_i;
          REG_Y_HI:   y_hi_q   <= cfg_data_i;
          REG_X_SPAN: x_span_q <= cfg_data_i;
          REG_Y_SPAN: y_span_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.shift_clr) begin
        shift_q <= '0;
      end else if (cmd_i.shift_en) begin
        shift_q <= {shift_q[ADC_BITS-2:0], miso_i};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_start) begin
      diff_q <= CFG_W'(diff_w);
      den_q  <= hi - lo;
      span_q <= cmd_i.axis ? y_span_q : x_span_q;
      win_q  <= in_win;
    end
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(diff_q) * PROD_W'(span_q);
    end
    if (cmd_i.fin_store) begin
      if (cmd_i.axis) begin
        y_res_q <= val;
      end else begin
        x_res_q <= val;
      end
    end
    if (cmd_i.out_load) begin
      out_q.chip_select_n <= cmd_i.line.chip_select_n;
      out_q.serial_clock  <= cmd_i.line.serial_clock;
      out_q.mosi_bit      <= cmd_i.line.mosi_bit;
      out_q.done_res      <= cmd_i.line.done_res;
      out_q.busy_res      <= cmd_i.line.busy_res;
      out_q.x_position    <= cmd_i.line.done_res ? x_res_q : '0;
      out_q.y_position    <= cmd_i.line.done_res ? val : '0;
    end
  end

  assign out_o = out_q;

endmodule

// ----- design/tasr_ctrl.sv -----
// ----------------------------------------------------------------------------
// tasr_ctrl: serial sequencer and handshake controller
// Walks command, data, trailing and finish phases one tick per request and
// steps the datapath through the calibration multiply and divide.
// ----------------------------------------------------------------------------
module tasr_ctrl
  import tasr_pkg::*;
#(
  parameter int ADC_BITS        = ADC_BITS_DEF,
  parameter int TRAILING_CLOCKS = TRAIL_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dp_cmd_t  cmd_o,
  input  dp_sts_t  sts_i
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_CMD, PH_DATA, PH_TRAIL, PH_FINISH
  } phase_e;

  typedef enum logic [1:0] {
    ST_RUN, ST_MUL, ST_DSTART, ST_DIV
  } state_e;

  localparam logic [BIT_W-1:0] CMD_LAST   = BIT_W'(CMD_BITS - 1);
  localparam logic [BIT_W-1:0] DATA_LAST  = BIT_W'(ADC_BITS - 1);
  localparam logic [BIT_W-1:0] TRAIL_LAST = BIT_W'(TRAILING_CLOCKS - 1);

  state_e           state_q, state_d;
  phase_e           phase_q, cur_phase, nxt_phase;
  logic [BIT_W-1:0] bit_q, cur_bit, nxt_bit;
  logic             half_q, cur_half, nxt_half;
  logic             axis_q, cur_axis, nxt_axis;
  logic             mode_q, cur_mode;
  logic             out_valid_q, out_valid_d;
  logic             tick_clr, tick_shift, tick_fin;
  logic             commit, acc;
  logic [CMD_BITS-1:0] cmd_byte;
  line_t            line;

  assign in_ready_o  = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign cmd_byte    = cur_axis ? CMD_Y : CMD_X;

  // effect of one tick on the sequence and the pins
  always_comb begin
    cur_phase  = phase_q;
    cur_bit    = bit_q;
    cur_half   = half_q;
    cur_axis   = axis_q;
    cur_mode   = mode_q;
    tick_clr   = 1'b0;
    tick_shift = 1'b0;
    tick_fin   = 1'b0;
    line       = '{chip_select_n: 1'b1, serial_clock: 1'b0, mosi_bit: 1'b0,
                   done_res: 1'b0, busy_res: 1'b1};
    if (phase_q == PH_IDLE) begin
      if (in_i.start_req) begin
        // start tick is already the first command half-bit
        cur_phase = PH_CMD;
        cur_bit   = CMD_LAST;
        cur_half  = 1'b0;
        cur_axis  = 1'b0;
        cur_mode  = in_i.calibrate;
        tick_clr  = 1'b1;
      end else begin
        line.busy_res = 1'b0;
      end
    end
    nxt_phase = cur_phase;
    nxt_bit   = cur_bit;
    nxt_half  = cur_half;
    nxt_axis  = cur_axis;
    case (cur_phase)
      PH_CMD: begin
        line.chip_select_n = 1'b0;
        line.serial_clock  = cur_half;
        line.mosi_bit      = cmd_byte[cur_bit[2:0]];
        nxt_half           = ~cur_half;
        if (cur_half) begin
          if (cur_bit == '0) begin
            nxt_phase = PH_DATA;
            nxt_bit   = DATA_LAST;
          end else begin
            nxt_bit = cur_bit - 1'b1;
          end
        end
      end
      PH_DATA: begin
        line.chip_select_n = 1'b0;
        line.serial_clock  = ~cur_half;
        tick_shift         = cur_half;   // sample on the clock-low tick
        nxt_half           = ~cur_half;
        if (cur_half) begin
          if (cur_bit == '0) begin
            if (TRAILING_CLOCKS == 0) begin
              nxt_phase = PH_FINISH;
            end else begin
              nxt_phase = PH_TRAIL;
              nxt_bit   = TRAIL_LAST;
            end
          end else begin
            nxt_bit = cur_bit - 1'b1;
          end
        end
      end
      PH_TRAIL: begin
        line.chip_select_n = 1'b0;
        line.serial_clock  = ~cur_half;
        nxt_half           = ~cur_half;
        if (cur_half) begin
          if (cur_bit == '0) begin
            nxt_phase = PH_FINISH;
          end else begin
            nxt_bit = cur_bit - 1'b1;
          end
        end
      end
      PH_FINISH: begin
        tick_fin = 1'b1;
        if (!cur_axis) begin
          nxt_axis  = 1'b1;
          nxt_phase = PH_CMD;
          nxt_bit   = CMD_LAST;
          nxt_half  = 1'b0;
          tick_clr  = 1'b1;
        end else begin
          nxt_phase     = PH_IDLE;
          nxt_bit       = '0;
          nxt_half      = 1'b0;
          line.done_res = 1'b1;
          line.busy_res = 1'b0;
        end
      end
      PH_IDLE: ;
      default: begin
        nxt_phase     = PH_IDLE;
        line.busy_res = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    commit      = 1'b0;
    cmd_o       = '0;
    cmd_o.line  = line;
    cmd_o.axis  = cur_axis;
    cmd_o.cal   = mode_q;
    case (state_q)
      ST_RUN: begin
        if (acc) begin
          if (tick_fin && mode_q) begin
            cmd_o.calc_start = 1'b1;
            state_d          = ST_MUL;
          end else begin
            commit = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_DSTART;
      end
      ST_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        // sequence registers held still; finish tick is applied once the divider is done
        if (sts_i.div_done) begin
          commit  = 1'b1;
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
    if (commit) begin
      cmd_o.out_load  = 1'b1;
      cmd_o.shift_clr = tick_clr;
      cmd_o.shift_en  = tick_shift;
      cmd_o.fin_store = tick_fin;
      out_valid_d     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      phase_q     <= PH_IDLE;
      bit_q       <= '0;
      half_q      <= 1'b0;
      axis_q      <= 1'b0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        phase_q <= nxt_phase;
        bit_q   <= nxt_bit;
        half_q  <= nxt_half;
        axis_q  <= nxt_axis;
        mode_q  <= cur_mode;
      end
    end
  end

endmodule

// ----- design/touch_adc_spi_reader.sv -----
// ----------------------------------------------------------------------------
// touch_adc_spi_reader: serial master for a resistive touch-panel converter
// Reads X then Y, one half-bit tick per request, and returns raw or
// calibrated positions.
// ----------------------------------------------------------------------------
// Each request is one half-bit tick and yields one result carrying the pin
// levels for that tick. Ordinary ticks load their result at the accepting
// clock, and a new request is taken only when no result waits or the waiting
// one is taken in the same cycle. In calibrated mode the finishing tick of an
// axis holds off requests throughout its steps: the window check and the
// difference, the 12x12 multiply, loading the divider, the restoring divider,
// which produces one quotient bit per cycle, and storing the result. In raw
// mode the finishing tick is handled like any other tick; a calibrated reading
// outside its window still waits for the full divider run. Configuration
// writes are taken at once and must only be made while no read is in progress.
// ----------------------------------------------------------------------------
module touch_adc_spi_reader
  import tasr_pkg::*;
#(
  parameter int ADC_BITS        = ADC_BITS_DEF,
  parameter int TRAILING_CLOCKS = TRAIL_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tasr_ctrl #(
    .ADC_BITS        (ADC_BITS),
    .TRAILING_CLOCKS (TRAILING_CLOCKS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tasr_dp #(
    .ADC_BITS (ADC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .miso_i     (in_i.miso_bit),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_o      (out_o)
  );

  // an accepted request either loads a result or holds off further requests
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o || !in_ready_o)
    else $error("accepted request produced neither result nor stall");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.done_res |-> !out_o.busy_res && out_o.chip_select_n)
    else $error("done tick with busy or select active");

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.done_res |-> out_o.x_position == '0 &&
                                       out_o.y_position == '0)
    else $error("positions non-zero outside done tick");

  a_select_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.chip_select_n |-> out_o.busy_res)
    else $error("select active while not busy");

endmodule

// ----- sim/touch_adc_spi_reader_tb.sv -----
// ----------------------------------------------------------------------------
// touch_adc_spi_reader_tb: self-checking bench for the touch converter reader
// Drives whole X/Y read sequences tick by tick with random converter data and
// random flow control, predicts every tick's pin levels and positions, and
// compares each returned result against the oldest prediction.
// ----------------------------------------------------------------------------

typedef enum logic [2:0] {
  SEQ_IDLE,
  SEQ_CMD,
  SEQ_DATA,
  SEQ_TRAIL,
  SEQ_FINISH
} seq_phase_e;

class touch_read_scoreboard;
  logic [tasr_pkg::CFG_W-1:0] x_lo, x_hi, y_lo, y_hi, x_span, y_span;
  seq_phase_e                 phase;
  logic [tasr_pkg::BIT_W-1:0] bit_cnt;
  logic                       half;
  logic                       axis;
  logic [15:0]                shift_reg;
  logic                       mode;
  logic [tasr_pkg::POS_W-1:0] x_res, y_res;
  tasr_pkg::out_item_t        tick_q[$];
  int                         errors;

  function new();
    x_lo   = tasr_pkg::RST_X_LO;
    x_hi   = tasr_pkg::RST_X_HI;
    y_lo   = tasr_pkg::RST_Y_LO;
    y_hi   = tasr_pkg::RST_Y_HI;
    x_span = tasr_pkg::RST_X_SPAN;
    y_span = tasr_pkg::RST_Y_SPAN;
    phase     = SEQ_IDLE;
    bit_cnt   = '0;
    half      = 1'b0;
    axis      = 1'b0;
    shift_reg = '0;
    mode      = 1'b0;
    x_res     = '0;
    y_res     = '0;
    errors    = 0;
  endfunction

  function void write_reg(logic [tasr_pkg::IDX_W-1:0] idx, logic [tasr_pkg::CFG_W-1:0] val);
    case (idx)
      tasr_pkg::REG_X_LO:   x_lo   = val;
      tasr_pkg::REG_X_HI:   x_hi   = val;
      tasr_pkg::REG_Y_LO:   y_lo   = val;
      tasr_pkg::REG_Y_HI:   y_hi   = val;
      tasr_pkg::REG_X_SPAN: x_span = val;
      tasr_pkg::REG_Y_SPAN: y_span = val;
      default: ;
    endcase
  endfunction

  function logic [tasr_pkg::POS_W-1:0] scale(logic [15:0] raw, logic [11:0] lo,
                                             logic [11:0] hi, logic [11:0] span,
                                             bit inverted);
    logic [11:0]     diff;
    longint unsigned quot;
    if (raw < {4'd0, lo} || raw > {4'd0, hi} || hi <= lo) return '0;
    diff = inverted ? hi - raw[11:0] : raw[11:0] - lo;
    quot = (longint'(diff) * longint'(span)) / longint'(hi - lo);
    return quot[11:0];
  endfunction

  function void begin_axis();
    phase     = SEQ_CMD;
    bit_cnt   = 4'(tasr_pkg::CMD_BITS - 1);
    half      = 1'b0;
    shift_reg = '0;
  endfunction

  // true once the last half of the last bit has gone
  function bit step_bit();
    if (!half) begin
      half = 1'b1;
      return 1'b0;
    end
    half = 1'b0;
    if (bit_cnt == 0) return 1'b1;
    bit_cnt--;
    return 1'b0;
  endfunction

  function void note_request(tasr_pkg::in_item_t req);
    tasr_pkg::out_item_t           exp_t;
    logic [tasr_pkg::CMD_BITS-1:0] cmd;
    exp_t = '0;
    exp_t.chip_select_n = 1'b1;
    exp_t.busy_res      = 1'b1;
    if (phase == SEQ_IDLE) begin
      if (req.start_req) begin
        mode = req.calibrate;
        axis = 1'b0;
        begin_axis();
      end else begin
        exp_t.busy_res = 1'b0;
      end
    end
    case (phase)
      SEQ_CMD: begin
        cmd = axis ? tasr_pkg::CMD_Y : tasr_pkg::CMD_X;
        exp_t.chip_select_n = 1'b0;
        exp_t.serial_clock  = half;
        exp_t.mosi_bit      = cmd[bit_cnt[2:0]];
        if (step_bit()) begin
          phase   = SEQ_DATA;
          bit_cnt = 4'(tasr_pkg::ADC_BITS_DEF - 1);
        end
      end
      SEQ_DATA: begin
        exp_t.chip_select_n = 1'b0;
        exp_t.serial_clock  = ~half;
        if (half) shift_reg = {shift_reg[14:0], req.miso_bit};
        if (step_bit()) begin
          if (tasr_pkg::TRAIL_DEF == 0) begin
            phase = SEQ_FINISH;
          end else begin
            phase   = SEQ_TRAIL;
            bit_cnt = 4'(tasr_pkg::TRAIL_DEF - 1);
          end
        end
      end
      SEQ_TRAIL: begin
        exp_t.chip_select_n = 1'b0;
        exp_t.serial_clock  = ~half;
        if (step_bit()) phase = SEQ_FINISH;
      end
      SEQ_FINISH: begin
        if (!axis) begin
          x_res = mode ? scale(shift_reg, x_lo, x_hi, x_span, 1'b0) : shift_reg[11:0];
          axis  = 1'b1;
          begin_axis();
        end else begin
          y_res   = mode ? scale(shift_reg, y_lo, y_hi, y_span, 1'b1) : shift_reg[11:0];
          phase   = SEQ_IDLE;
          bit_cnt = '0;
          half    = 1'b0;
          exp_t.done_res   = 1'b1;
          exp_t.busy_res   = 1'b0;
          exp_t.x_position = x_res;
          exp_t.y_position = y_res;
        end
      end
      default: ;
    endcase
    tick_q.push_back(exp_t);
  endfunction

  function void compare_field(string name, logic [tasr_pkg::POS_W-1:0] exp_v,
                              logic [tasr_pkg::POS_W-1:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endfunction

  function void check_result(tasr_pkg::out_item_t got);
    tasr_pkg::out_item_t exp_t;
    if (tick_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got %h", $time, got);
      return;
    end
    exp_t = tick_q.pop_front();
    compare_field("chip_select_n", 12'(exp_t.chip_select_n), 12'(got.chip_select_n));
    compare_field("serial_clock", 12'(exp_t.serial_clock), 12'(got.serial_clock));
    compare_field("mosi_bit", 12'(exp_t.mosi_bit), 12'(got.mosi_bit));
    compare_field("done_res", 12'(exp_t.done_res), 12'(got.done_res));
    compare_field("x_position", exp_t.x_position, got.x_position);
    compare_field("y_position", exp_t.y_position, got.y_position);
    compare_field("busy_res", 12'(exp_t.busy_res), 12'(got.busy_res));
  endfunction
endclass

module touch_adc_spi_reader_tb;
  import tasr_pkg::*;

  localparam int AXIS_TICKS   = 2 * (CMD_BITS + ADC_BITS_DEF + TRAIL_DEF) + 1;
  localparam int DATA_FIRST   = 2 * CMD_BITS;
  localparam int RANDOM_ITEMS = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int END_WAIT     = 40;
  // indexes past the last register, writes there must change nothing
  localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_item_t         in_i        = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_item_t        out_o;
  logic             cfg_we_i    = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  touch_read_scoreboard sb;
  bit tx_idle   = 1'b1;
  bit rx_idle   = 1'b1;
  bit hold_req  = 1'b0;
  int sent_cnt  = 0;

  touch_adc_spi_reader i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  initial begin
    #(4 * 3_000_000);
    $display("touch_adc_spi_reader_tb: done, errors");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    int stall_cnt;
    int hold_cnt;
    stall_cnt = 0;
    hold_cnt  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_o);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready_i <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        stall_cnt = $urandom_range(1, 17) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_tick(input in_item_t req);
    in_valid_i <= 1'b1;
    in_i       <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req);
    sent_cnt++;
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic idle_ticks(input int n);
    in_item_t req;
    repeat (n) begin
      req.start_req = 1'b0;
      req.calibrate = 1'($urandom_range(0, 1));
      req.miso_bit  = 1'($urandom_range(0, 1));
      send_tick(req);
    end
  endtask

  // one full X then Y read; the converter returns raw_x and raw_y
  task automatic do_read(input logic cal, input logic [11:0] raw_x, input logic [11:0] raw_y);
    in_item_t    req;
    int          k;
    logic [11:0] val;
    for (int t = 0; t < 2 * AXIS_TICKS; t++) begin
      k   = t % AXIS_TICKS;
      val = (t < AXIS_TICKS) ? raw_x : raw_y;
      // start and mode are ignored after the first tick, so scramble them
      req.start_req = (t == 0) ? 1'b1 : 1'($urandom_range(0, 1));
      req.calibrate = (t == 0) ? cal : 1'($urandom_range(0, 1));
      if (k >= DATA_FIRST && k < DATA_FIRST + 2 * ADC_BITS_DEF)
        req.miso_bit = val[ADC_BITS_DEF - 1 - (k - DATA_FIRST) / 2];
      else
        req.miso_bit = 1'($urandom_range(0, 1));
      send_tick(req);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.tick_q.size() != 0);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_config(input logic [CFG_W-1:0] xl, xh, yl, yh, xs, ys);
    write_reg(REG_X_LO, xl);
    write_reg(REG_X_HI, xh);
    write_reg(REG_Y_LO, yl);
    write_reg(REG_Y_HI, yh);
    write_reg(REG_X_SPAN, xs);
    write_reg(REG_Y_SPAN, ys);
    write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 12'($urandom_range(0, 4095)));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // window edges, just outside them, inside, or anything at all
  function automatic logic [11:0] pick_raw(input logic [11:0] lo, input logic [11:0] hi);
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      2: return lo - 12'd1;
      3: return hi + 12'd1;
      7: return 12'($urandom_range(0, 4095));
      default: return (lo <= hi) ? 12'($urandom_range(lo, hi)) : 12'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin
    int               rand_base;
    int               phase_no;
    logic [CFG_W-1:0] xl, xh, yl, yh;
    in_item_t         req;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle ticks, raw extremes, default window edges
    req = '0;
    send_tick(req);
    req.calibrate = 1'b1;
    req.miso_bit  = 1'b1;
    send_tick(req);
    do_read(1'b0, 12'd4095, 12'd0);
    do_read(1'b1, RST_X_LO, RST_Y_HI);
    do_read(1'b1, RST_X_HI + 12'd1, RST_Y_LO - 12'd1);
    drain();
    apply_config(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd4095);
    do_read(1'b1, 12'd4095, 12'd0);
    drain();
    // empty windows: equal bounds on X, crossed bounds on Y
    apply_config(12'd2000, 12'd2000, 12'd3000, 12'd100, 12'd1, 12'd1);
    do_read(1'b1, 12'd2000, 12'd1000);
    drain();
    apply_config(12'd4094, 12'd4095, 12'd0, 12'd1, 12'd1, 12'd4095);
    do_read(1'b1, 12'd4095, 12'd0);

    rand_base = sent_cnt;
    phase_no  = 0;
    while (sent_cnt - rand_base < RANDOM_ITEMS) begin
      drain();
      if (phase_no % 4 == 3) begin
        xl = $urandom_range(0, 1) ? 12'd0 : 12'd4095;
        yl = $urandom_range(0, 1) ? 12'd0 : 12'd4095;
        apply_config(xl, ~xl, yl, ~yl, $urandom_range(0, 1) ? 12'd1 : 12'd4095,
                     $urandom_range(0, 1) ? 12'd1 : 12'd4095);
      end else begin
        xl = 12'($urandom_range(0, 4095));
        xh = 12'($urandom_range(0, 4095));
        yl = 12'($urandom_range(0, 4095));
        yh = 12'($urandom_range(0, 4095));
        if (xl > xh && $urandom_range(0, 7) != 0) {xl, xh} = {xh, xl};
        if (yl > yh && $urandom_range(0, 7) != 0) {yl, yh} = {yh, yl};
        apply_config(xl, xh, yl, yh, 12'($urandom_range(1, 4095)),
                     12'($urandom_range(1, 4095)));
      end
      // the closing quarter runs with no idling on either side
      tx_idle = (sent_cnt - rand_base < RANDOM_ITEMS * 3 / 4) && $urandom_range(0, 3) != 0;
      rx_idle = (sent_cnt - rand_base < RANDOM_ITEMS * 3 / 4) && $urandom_range(0, 3) != 0;
      if (phase_no == 0) hold_req = 1'b1;
      repeat ($urandom_range(1, 3)) begin
        idle_ticks($urandom_range(0, 4));
        do_read($urandom_range(0, 3) != 0, pick_raw(sb.x_lo, sb.x_hi),
                pick_raw(sb.y_lo, sb.y_hi));
      end
      phase_no++;
    end

    // closing read, always free of idling on both sides
    drain();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    do_read(1'b1, pick_raw(sb.x_lo, sb.x_hi), pick_raw(sb.y_lo, sb.y_hi));

    drain();
    repeat (END_WAIT) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("touch_adc_spi_reader_tb: done, clean");
    end else begin
      $display("touch_adc_spi_reader_tb: done, errors");
    end
    $finish;
  end

endmodule
